### sv/mkd_pkg.sv
// shared types and constants for the multi-key edge debouncer
// no dependencies; imported by the front, back and top level
`timescale 1ns / 1ps
`default_nettype none

package mkd_pkg;

    typedef struct packed {
        logic        op;
        logic        key_index;
        logic        edge_rising;
        logic [31:0] edge_time;
    } t_in_item;

    typedef struct packed {
        logic        confirmed_key;
        logic        confirmed_rising;
        logic [31:0] confirmed_time;
        logic        last_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        KEY_UP      = 2'd0,
        KEY_FALLING = 2'd1,
        KEY_DOWN    = 2'd2,
        KEY_RISING  = 2'd3
    } t_key_state;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_QUIET = 1'b1;

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

endpackage

`default_nettype wire

### sv/mkd_fifo.sv
// small first-word-fall-through queue, generic width and depth
// no package dependencies; used for the command and result queues
`timescale 1ns / 1ps
`default_nettype none

module mkd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push, pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

### sv/mkd_front.sv
// front end: accepts items, drops edges for absent keys, trims stamps, queues commands
// depends on mkd_pkg and mkd_fifo
`timescale 1ns / 1ps
`default_nettype none

module mkd_front #(
    parameter int NUM_KEYS   = 2,
    parameter int STAMP_BITS = 32,
    parameter int KW         = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire mkd_pkg::t_in_item     i_in,
    output logic                       o_full,
    output logic                       o_cmd_valid,
    output logic                       o_cmd_quiet,
    output logic      [KW-1:0]         o_cmd_key,
    output logic                       o_cmd_rising,
    output logic      [STAMP_BITS-1:0] o_cmd_stamp,
    input  wire logic                  i_cmd_pop
);

    import mkd_pkg::*;

    localparam int CMDW = 2 + KW + STAMP_BITS;

    logic [63:0]           time_wide;
    logic [STAMP_BITS-1:0] stamp;
    logic                  in_range;
    logic                  keep;
    logic [CMDW-1:0]       wdata, rdata;
    logic                  cmd_empty;

    assign time_wide = 64'(i_in.edge_time);
    assign stamp     = time_wide[STAMP_BITS-1:0];
    assign in_range  = (32'(i_in.key_index) < 32'(NUM_KEYS));
    // edges for keys that do not exist never reach the back end
    assign keep      = (i_in.op == OP_QUIET) || in_range;
    assign wdata     = {(i_in.op == OP_QUIET), KW'(i_in.key_index), i_in.edge_rising, stamp};

    mkd_fifo #(
        .WIDTH(CMDW),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push && keep),
        .i_wdata(wdata),
        .o_full (o_full),
        .i_pop  (i_cmd_pop),
        .o_rdata(rdata),
        .o_empty(cmd_empty)
    );

    assign o_cmd_valid  = !cmd_empty;
    assign o_cmd_quiet  = rdata[CMDW-1];
    assign o_cmd_key    = rdata[CMDW-2 -: KW];
    assign o_cmd_rising = rdata[STAMP_BITS];
    assign o_cmd_stamp  = rdata[STAMP_BITS-1:0];

endmodule

`default_nettype wire

### sv/mkd_back.sv
// back end: per-key debounce state, edge updates and confirmation scan
// depends on mkd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mkd_back #(
    parameter int NUM_KEYS   = 2,
    parameter int STAMP_BITS = 32,
    parameter int KW         = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    input  wire logic                  i_cmd_quiet,
    input  wire logic [KW-1:0]         i_cmd_key,
    input  wire logic                  i_cmd_rising,
    input  wire logic [STAMP_BITS-1:0] i_cmd_stamp,
    output logic                       o_cmd_pop,
    output logic                       o_res_valid,
    output mkd_pkg::t_out_item         o_res_item,
    input  wire logic                  i_res_full
);

    import mkd_pkg::*;

    t_key_state            r_state [NUM_KEYS];
    t_key_state            n_state [NUM_KEYS];
    logic [STAMP_BITS-1:0] r_stamp [NUM_KEYS];
    logic [STAMP_BITS-1:0] n_stamp [NUM_KEYS];
    logic [NUM_KEYS-1:0]   pending;
    logic [NUM_KEYS-1:0]   rest;
    logic [KW-1:0]         sel;
    logic [63:0]           sel_wide;
    logic                  only_one;

    // falling and rising both carry a set low bit
    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            pending[k] = r_state[k][0];
        end
    end

    always_comb begin
        sel = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (pending[k]) begin
                sel = KW'(k);
            end
        end
    end

    assign rest     = pending & (pending - 1'b1);
    assign only_one = (rest == '0);
    assign sel_wide = 64'(r_stamp[sel]);

    always_comb begin
        o_res_item.confirmed_key    = sel[0];
        o_res_item.confirmed_rising = r_state[sel][1];
        o_res_item.confirmed_time   = sel_wide[31:0];
        o_res_item.last_of_run      = only_one;
    end

    always_comb begin
        n_state     = r_state;
        n_stamp     = r_stamp;
        o_cmd_pop   = 1'b0;
        o_res_valid = 1'b0;
        if (i_cmd_valid && !i_cmd_quiet) begin
            o_cmd_pop = 1'b1;
            case (r_state[i_cmd_key])
                KEY_UP: begin
                    if (!i_cmd_rising) begin
                        n_state[i_cmd_key] = KEY_FALLING;
                        n_stamp[i_cmd_key] = i_cmd_stamp;
                    end
                end
                KEY_FALLING: begin
                    n_state[i_cmd_key] = KEY_UP;
                    n_stamp[i_cmd_key] = i_cmd_stamp;
                end
                KEY_DOWN: begin
                    if (i_cmd_rising) begin
                        n_state[i_cmd_key] = KEY_RISING;
                        n_stamp[i_cmd_key] = i_cmd_stamp;
                    end
                end
                KEY_RISING: begin
                    n_state[i_cmd_key] = KEY_DOWN;
                    n_stamp[i_cmd_key] = i_cmd_stamp;
                end
                default: begin
                    n_state[i_cmd_key] = KEY_UP;
                end
            endcase
        end else if (i_cmd_valid) begin
            // quiet transaction stays at the queue head until every pending key is confirmed
            if (pending == '0) begin
                o_cmd_pop = 1'b1;
            end else if (!i_res_full) begin
                o_res_valid  = 1'b1;
                o_cmd_pop    = only_one;
                n_state[sel] = r_state[sel][1] ? KEY_UP : KEY_DOWN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_state[k] <= KEY_UP;
                r_stamp[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_stamp <= n_stamp;
        end
    end

endmodule

`default_nettype wire

### sv/multi_key_edge_debouncer.sv
// top level of the multi-key edge debouncer: front end, back end and result queue
// depends on mkd_pkg, mkd_fifo, mkd_front and mkd_back
//
//   channel | direction | handshake          | payload
//   input   | in        | i_push / o_full    | i_in  (t_in_item)
//   result  | out       | o_empty / i_pop    | o_out (t_out_item)
//
// the key engine retires an edge transaction without waiting on the result queue; a quiet
// transaction confirms pending keys one at a time through the single-key confirmation scan,
// and with no key pending it retires without a result
// reset is synchronous and returns every key to up with a zero stamp; no clearing pass
// a full result queue stalls the key engine only on a quiet command with pending keys; input keeps flowing into the
// two-entry command queue until it fills
`timescale 1ns / 1ps
`default_nettype none

module multi_key_edge_debouncer #(
    parameter int NUM_KEYS   = 2,
    parameter int STAMP_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mkd_pkg::t_in_item  i_in,
    output logic                    o_full,
    input  wire logic               i_pop,
    output mkd_pkg::t_out_item      o_out,
    output logic                    o_empty
);

    import mkd_pkg::*;

    localparam int KW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int RESW = $bits(t_out_item);

    logic                  cmd_valid;
    logic                  cmd_quiet;
    logic [KW-1:0]         cmd_key;
    logic                  cmd_rising;
    logic [STAMP_BITS-1:0] cmd_stamp;
    logic                  cmd_pop;
    logic                  res_push;
    logic                  res_full;
    t_out_item             res_item;
    logic [RESW-1:0]       res_rdata;

    mkd_front #(
        .NUM_KEYS  (NUM_KEYS),
        .STAMP_BITS(STAMP_BITS),
        .KW        (KW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd_quiet (cmd_quiet),
        .o_cmd_key   (cmd_key),
        .o_cmd_rising(cmd_rising),
        .o_cmd_stamp (cmd_stamp),
        .i_cmd_pop   (cmd_pop)
    );

    mkd_back #(
        .NUM_KEYS  (NUM_KEYS),
        .STAMP_BITS(STAMP_BITS),
        .KW        (KW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd_quiet (cmd_quiet),
        .i_cmd_key   (cmd_key),
        .i_cmd_rising(cmd_rising),
        .i_cmd_stamp (cmd_stamp),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_push),
        .o_res_item  (res_item),
        .i_res_full  (res_full)
    );

    mkd_fifo #(
        .WIDTH(RESW),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_wdata(res_item),
        .o_full (res_full),
        .i_pop  (i_pop),
        .o_rdata(res_rdata),
        .o_empty(o_empty)
    );

    assign o_out = t_out_item'(res_rdata);

    // results come only from a quiet transaction at the queue head
    a_res_from_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (cmd_valid && cmd_quiet))
        else $error("result produced without a quiet command");

    // the engine never writes into a full result queue
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result queue overflow");

    // a quiet command that retires with a result does so on the same cycle as the marked final result
    a_quiet_retire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_pop && cmd_quiet && res_push) |-> res_item.last_of_run)
        else $error("quiet command retired before its final result");

    // a marked final result retires its quiet command
    a_last_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && res_item.last_of_run) |-> cmd_pop)
        else $error("final result did not retire the quiet command");

endmodule

`default_nettype wire
